/* src/lpls_pkg.sv */
// Shared types, codes and helpers for the LED pulse link and light sensor.
`timescale 1ns / 1ps

package lpls_pkg;

    // Timer and frame sizing
    localparam int TIMER_WIDTH    = 16;
    localparam int BITS_PER_FRAME = 8;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int BYTE_W         = 8;

    // Item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SEND    = 2'd1;
    localparam logic [1:0] KIND_MEASURE = 2'd2;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MARK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] MARK_RESET      = 16'd1000;
    localparam logic [CFG_W-1:0] SPACE_RESET     = 16'd500;
    localparam logic [CFG_W-1:0] PERIOD_RESET    = 16'd5000;
    localparam logic [CFG_W-1:0] CHARGE_RESET    = 16'd1000;
    localparam logic [CFG_W-1:0] WINDOW_RESET    = 16'd5000;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd2500;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data_byte;
        logic              cathode_sample;
    } item_t;

    typedef struct packed {
        logic anode_output_enable;
        logic anode_drive;
        logic cathode_output_enable;
        logic cathode_drive;
        logic busy_res;
        logic send_done;
        logic level_valid;
        logic light_level;
        logic rejected;
    } result_t;

    // Clamp a register-width wait to the timer range
    function automatic logic [TIMER_WIDTH-1:0] sat_timer(input logic [CFG_W-1:0] v);
        logic [CFG_W+TIMER_WIDTH-1:0] wide;
        logic [CFG_W+TIMER_WIDTH-1:0] lim;
        wide = {{TIMER_WIDTH{1'b0}}, v};
        lim  = {{CFG_W{1'b0}}, {TIMER_WIDTH{1'b1}}};
        if (wide > lim)
        begin
            sat_timer = '1;
        end
        else
        begin
            sat_timer = wide[TIMER_WIDTH-1:0];
        end
    endfunction

endpackage

/* src/led_pulse_link_and_light_sense.sv */
// Top level: LED pulse-width transmitter and discharge-time light sensor.
// Datapath: an accepted item passes through the input register, then the result
// register, which presents its result beat; one item per clock is sustained while
// the result side keeps up. All of an item's work, including chains of zero-length
// waits, is resolved combinationally between the input register and the result
// register.
// Reset (rst_n, asynchronous, active low): idle, pins unconfigured, timing
// registers at their default values; items are accepted right after reset.
`timescale 1ns / 1ps

module led_pulse_link_and_light_sense (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  lpls_pkg::item_t                    item_data,
    // result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output lpls_pkg::result_t                  res_data,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpls_pkg::CFG_W-1:0]         cfg_data
);

    localparam int TW        = lpls_pkg::TIMER_WIDTH;
    localparam int CW        = lpls_pkg::CFG_W;
    localparam int BPF       = lpls_pkg::BITS_PER_FRAME;
    localparam int BW        = lpls_pkg::BYTE_W;
    localparam int LEFT_W    = $clog2(BPF + 1);
    localparam int FRAME_W   = (BPF > BW) ? BPF : BW;
    localparam int ELAPSED_W = CW + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EMIT,
        PH_RBIAS,
        PH_CHARGE,
        PH_SENSE,
        PH_PAD
    } phase_t;

    typedef enum logic [1:0] {
        PM_NONE,
        PM_EMIT,
        PM_RBIAS,
        PM_DISCH
    } pin_t;

    // Outcome of starting the next bit of a frame
    typedef struct packed {
        phase_t            phase;
        pin_t              pin;
        logic [TW-1:0]     count;
        logic [BW-1:0]     shift;
        logic [LEFT_W-1:0] left;
        logic              done;
    } bit_res_t;

    // Start the next of the n bits left in the frame held in s, skipping every bit whose emit and
    // reverse-bias waits are both zero; done when the frame runs out.
    function automatic bit_res_t start_bits(
        input logic [BW-1:0]     s,
        input logic [LEFT_W-1:0] n,
        input logic [CW-1:0]     mark,
        input logic [CW-1:0]     space,
        input logic [CW-1:0]     period
    );
        logic [FRAME_W-1:0] s_ext;
        logic [FRAME_W-1:0] s_sh;
        logic [LEFT_W-1:0]  k;
        logic               found;
        logic [CW-1:0]      d;
        bit_res_t           r;
        s_ext = FRAME_W'(s);
        k     = n;
        found = 1'b0;
        for (int i = 0; i < BPF; i++)
        begin
            if (!found && (LEFT_W'(i) < n))
            begin
                if (!((period == '0) && (s_ext[i] ? (mark == '0) : (space == '0))))
                begin
                    found = 1'b1;
                    k     = LEFT_W'(i);
                end
            end
        end
        s_sh    = s_ext >> k;
        r.shift = s_sh[BW-1:0];
        r.left  = n - k;
        d       = s_sh[0] ? mark : space;
        if (!found)
        begin
            r.phase = PH_IDLE;
            r.pin   = PM_RBIAS;
            r.count = '0;
            r.done  = 1'b1;
        end
        else if (d != '0)
        begin
            r.phase = PH_EMIT;
            r.pin   = PM_EMIT;
            r.count = lpls_pkg::sat_timer(d);
            r.done  = 1'b0;
        end
        else
        begin
            r.phase = PH_RBIAS;
            r.pin   = PM_RBIAS;
            r.count = lpls_pkg::sat_timer(period);
            r.done  = 1'b0;
        end
        return r;
    endfunction

    // Configuration registers
    logic [CW-1:0] mark_reg, space_reg, period_reg, charge_reg, window_reg, thr_reg;

    // Pipeline registers
    logic              in_valid_reg, in_valid_next;
    lpls_pkg::item_t   in_item_reg;
    logic              out_valid_reg, out_valid_next;
    lpls_pkg::result_t out_data_reg, out_data_next;

    // Block state
    phase_t                 phase_reg, phase_next;
    pin_t                   pin_reg, pin_next;
    logic [TW-1:0]          count_reg, count_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [BW-1:0]          shift_reg, shift_next;
    logic [LEFT_W-1:0]      left_reg, left_next;

    logic          advance, fire, accept;
    logic          done, lvl_valid, level, rej;
    bit_res_t      bits;
    logic [BW-1:0]     bits_s;
    logic [LEFT_W-1:0] bits_n;
    logic [CW-1:0]     emit_d, rb_raw;
    logic [TW-1:0]     rb_wait, count_dec, charge_wait, pad_wait;
    logic [ELAPSED_W-1:0] e_inc;
    logic [ELAPSED_W-1:0] window_ext;

    // Handshake
    assign advance    = !out_valid_reg || !res_stall;
    assign fire       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_data_reg;

    // Shared bit starter: new frame on a send, else the rest of the current one
    always_comb
    begin
        if (in_item_reg.kind == lpls_pkg::KIND_SEND)
        begin
            bits_s = in_item_reg.data_byte;
            bits_n = LEFT_W'(BPF);
        end
        else
        begin
            bits_s = shift_reg >> 1;
            bits_n = left_reg - 1'b1;
        end
        bits = start_bits(bits_s, bits_n, mark_reg, space_reg, period_reg);
    end

    // Wait values
    assign emit_d      = shift_reg[0] ? mark_reg : space_reg;
    assign rb_raw      = (period_reg > emit_d) ? (period_reg - emit_d) : '0;
    assign rb_wait     = lpls_pkg::sat_timer(rb_raw);
    assign count_dec   = count_reg - 1'b1;
    assign charge_wait = lpls_pkg::sat_timer(charge_reg);
    assign e_inc       = elapsed_reg + 1'b1;
    assign window_ext  = {1'b0, window_reg};
    assign pad_wait    = lpls_pkg::sat_timer((window_ext > e_inc) ?
                                             CW'(window_ext - e_inc) : '0);

    // Next state for the item in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        pin_next     = pin_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        done         = 1'b0;
        lvl_valid    = 1'b0;
        level        = 1'b0;
        rej          = 1'b0;
        case (in_item_reg.kind)
            lpls_pkg::KIND_SEND:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    phase_next = bits.phase;
                    pin_next   = bits.pin;
                    count_next = bits.count;
                    shift_next = bits.shift;
                    left_next  = bits.left;
                    done       = bits.done;
                end
            end
            lpls_pkg::KIND_MEASURE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else if (charge_wait == '0)
                begin
                    phase_next   = PH_SENSE;
                    pin_next     = PM_DISCH;
                    count_next   = '0;
                    elapsed_next = '0;
                end
                else
                begin
                    phase_next = PH_CHARGE;
                    pin_next   = PM_RBIAS;
                    count_next = charge_wait;
                end
            end
            lpls_pkg::KIND_TICK:
            begin
                case (phase_reg)
                    PH_EMIT:
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            if (rb_wait != '0)
                            begin
                                phase_next = PH_RBIAS;
                                pin_next   = PM_RBIAS;
                                count_next = rb_wait;
                            end
                            else
                            begin
                                phase_next = bits.phase;
                                pin_next   = bits.pin;
                                count_next = bits.count;
                                shift_next = bits.shift;
                                left_next  = bits.left;
                                done       = bits.done;
                            end
                        end
                    end
                    PH_RBIAS:
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            phase_next = bits.phase;
                            pin_next   = bits.pin;
                            count_next = bits.count;
                            shift_next = bits.shift;
                            left_next  = bits.left;
                            done       = bits.done;
                        end
                    end
                    PH_CHARGE:
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            phase_next   = PH_SENSE;
                            pin_next     = PM_DISCH;
                            elapsed_next = '0;
                        end
                    end
                    PH_SENSE:
                    begin
                        elapsed_next = e_inc;
                        if ((e_inc > window_ext) || !in_item_reg.cathode_sample)
                        begin
                            if (pad_wait == '0)
                            begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                                lvl_valid  = 1'b1;
                                level      = e_inc > ELAPSED_W'(thr_reg);
                            end
                            else
                            begin
                                phase_next = PH_PAD;
                                count_next = pad_wait;
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            lvl_valid  = 1'b1;
                            level      = elapsed_reg > ELAPSED_W'(thr_reg);
                        end
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
            default:
            begin
                rej = 1'b0;
            end
        endcase
    end

    // Result beat
    always_comb
    begin
        out_data_next = '0;
        case (pin_next)
            PM_EMIT:
            begin
                out_data_next.anode_output_enable   = 1'b1;
                out_data_next.anode_drive           = 1'b1;
                out_data_next.cathode_output_enable = 1'b1;
            end
            PM_RBIAS:
            begin
                out_data_next.anode_output_enable   = 1'b1;
                out_data_next.cathode_output_enable = 1'b1;
                out_data_next.cathode_drive         = 1'b1;
            end
            PM_DISCH:
            begin
                out_data_next.anode_output_enable   = 1'b1;
            end
            default:
            begin
                out_data_next.anode_output_enable   = 1'b0;
            end
        endcase
        out_data_next.busy_res    = (phase_next != PH_IDLE);
        out_data_next.send_done   = done;
        out_data_next.level_valid = lvl_valid;
        out_data_next.light_level = lvl_valid && level;
        out_data_next.rejected    = rej;
    end

    // Valid flags
    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State, configuration and pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            pin_reg       <= PM_NONE;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            shift_reg     <= '0;
            left_reg      <= '0;
            mark_reg      <= lpls_pkg::MARK_RESET;
            space_reg     <= lpls_pkg::SPACE_RESET;
            period_reg    <= lpls_pkg::PERIOD_RESET;
            charge_reg    <= lpls_pkg::CHARGE_RESET;
            window_reg    <= lpls_pkg::WINDOW_RESET;
            thr_reg       <= lpls_pkg::THRESHOLD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg   <= phase_next;
                pin_reg     <= pin_next;
                count_reg   <= count_next;
                elapsed_reg <= elapsed_next;
                shift_reg   <= shift_next;
                left_reg    <= left_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lpls_pkg::REG_MARK:      mark_reg   <= cfg_data;
                    lpls_pkg::REG_SPACE:     space_reg  <= cfg_data;
                    lpls_pkg::REG_PERIOD:    period_reg <= cfg_data;
                    lpls_pkg::REG_CHARGE:    charge_reg <= cfg_data;
                    lpls_pkg::REG_WINDOW:    window_reg <= cfg_data;
                    lpls_pkg::REG_THRESHOLD: thr_reg    <= cfg_data;
                    default:                 thr_reg    <= thr_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item_data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks
    a_busy_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (pin_reg != PM_NONE))
        else $error("busy with pins unconfigured");

    a_sense_disch: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SENSE || phase_reg == PH_PAD) |-> (pin_reg == PM_DISCH))
        else $error("sensing without discharge pin mode");

    a_send_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EMIT || phase_reg == PH_RBIAS) |-> (left_reg != '0))
        else $error("sending with no bits left");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.send_done && out_data_reg.level_valid))
        else $error("send end and level report in one beat");

endmodule
